// ===== sv/bmp24_pkg.sv =====
// Shared constants and types for the 24-bit BMP to framebuffer decoder.
package bmp24_pkg;

  localparam int MAX_IMAGE_DIM = 4096;
  localparam int HEADER_BYTES  = 54;
  localparam int DIM_W         = $clog2(MAX_IMAGE_DIM) + 1;

  localparam logic [15:0] BMP_MAGIC = 16'h4D42;
  localparam logic [15:0] BMP_BPP24 = 16'd24;

  localparam logic [1:0] KIND_PIX    = 2'd0;
  localparam logic [1:0] KIND_BADFMT = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_SCREEN_W  = 3'd2;
  localparam logic [2:0] REG_SCREEN_H  = 3'd3;
  localparam logic [2:0] REG_BPP       = 3'd4;
  localparam logic [2:0] REG_STRIDE    = 3'd5;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // parser output, one per accepted byte
  typedef struct packed {
    logic             vld;
    logic             pix;
    logic             stat;
    logic [1:0]       kind;
    logic [DIM_W-1:0] fx;
    logic [DIM_W-1:0] fy;
    logic [23:0]      word;
  } bmp24_ev_t;

  // after clipping and the two address products
  typedef struct packed {
    logic        vld;
    logic        pix;
    logic        stat;
    logic [1:0]  kind;
    logic [27:0] prod_y;
    logic [16:0] prod_x;
    logic [23:0] word;
  } bmp24_mul_t;

  // queue entry: optional pixel write, then optional status
  typedef struct packed {
    logic        pix;
    logic        stat;
    logic [1:0]  kind;
    logic [27:0] addr;
    logic [23:0] word;
  } bmp24_res_t;

endpackage

// ===== sv/bmp24_stream_to_framebuffer_top.sv =====
// Top level of the 24-bit bottom-up BMP stream to framebuffer write decoder.
//
//  port group  | dir | payload
//  in_*        | in  | tdata[7:0] file_byte, tuser[0] file_start
//  out_*       | out | tdata[27:0] write_address, [51:28] pixel_word; tuser kind; tlast
//  cfg_*       | in  | index 0..5 origin_x, origin_y, screen_w, screen_h, bpp, stride
//
//  One byte request per cycle while in_tready is high; a result passes the parse
//  register, the multiply register and the queue. A byte giving a pixel write and
//  completion sends the write, then the completion. in_tready drops only when the
//  4-entry result queue plus in-flight stages could overflow. Reset is synchronous.
module bmp24_stream_to_framebuffer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // file_byte
  input  logic [0:0]  in_tuser,   // file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // write_address[27:0], pixel_word[51:28], zero
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import bmp24_pkg::*;

  logic [11:0] origin_x_r;
  logic [11:0] origin_y_r;
  logic [12:0] screen_w_r;
  logic [12:0] screen_h_r;
  logic [3:0]  bpp_r;
  logic [15:0] stride_r;

  logic            acc;
  bmp24_ev_t       ev;
  bmp24_mul_t      s2_r, s2_nxt;
  bmp24_res_t      push_ent;
  logic            push;
  logic [Q_CW-1:0] q_level;
  logic [Q_CW:0]   committed;
  logic [28:0]     prod_y_full;
  logic [27:0]     addr_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      screen_w_r <= 13'd1024;
      screen_h_r <= 13'd768;
      bpp_r      <= 4'd4;
      stride_r   <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata[11:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata[11:0];
        REG_SCREEN_W: screen_w_r <= cfg_wdata[12:0];
        REG_SCREEN_H: screen_h_r <= cfg_wdata[12:0];
        REG_BPP:      bpp_r      <= cfg_wdata[3:0];
        REG_STRIDE:   stride_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // every byte in flight can take at most one queue entry
  assign committed = (Q_CW + 1)'(q_level) + (Q_CW + 1)'(ev.vld) + (Q_CW + 1)'(s2_r.vld);
  assign in_tready = committed < (Q_CW + 1)'(Q_DEPTH);
  assign acc       = in_tvalid && in_tready;

  bmp24_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .file_byte  (in_tdata),
    .file_start (in_tuser[0]),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .ev         (ev)
  );

  always_comb begin
    prod_y_full   = ev.fy * stride_r;
    s2_nxt        = '0;
    s2_nxt.vld    = ev.vld;
    s2_nxt.pix    = ev.pix && (ev.fx < screen_w_r) && (ev.fy < screen_h_r);
    s2_nxt.stat   = ev.stat;
    s2_nxt.kind   = ev.kind;
    s2_nxt.prod_y = prod_y_full[27:0];
    s2_nxt.prod_x = ev.fx * bpp_r;
    s2_nxt.word   = ev.word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  assign addr_sum      = s2_r.prod_y + 28'(s2_r.prod_x);
  assign push          = s2_r.vld && (s2_r.pix || s2_r.stat);
  assign push_ent.pix  = s2_r.pix;
  assign push_ent.stat = s2_r.stat;
  assign push_ent.kind = s2_r.kind;
  assign push_ent.addr = s2_r.pix ? addr_sum : 28'd0;
  assign push_ent.word = s2_r.pix ? s2_r.word : 24'd0;

  bmp24_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ent   (push_ent),
    .level      (q_level),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    committed <= (Q_CW + 1)'(Q_DEPTH))
    else $error("result queue over-committed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PIX |-> out_tlast && out_tdata == 56'd0)
    else $error("status result not last or carries data");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_level < Q_CW'(Q_DEPTH) || (out_tvalid && out_tready && out_tlast))
    else $error("push into full result queue");

  a_pix_then_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tuser == KIND_DONE)
    else $error("pixel write not followed by completion");

endmodule

// ===== sv/bmp24_parse.sv =====
// Byte-level BMP header/pixel parser producing one registered event per byte.
module bmp24_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic [7:0]                file_byte,
  input  logic                      file_start,
  input  logic [11:0]               origin_x,
  input  logic [11:0]               origin_y,
  output bmp24_pkg::bmp24_ev_t      ev
);
  import bmp24_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [31:0]      pos_r, pos_nxt;
  logic [15:0]      magic_r, magic_nxt;
  logic [15:0]      bitcnt_r, bitcnt_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [1:0]       bip_r, bip_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [1:0]       pad_r, pad_nxt;
  bmp24_ev_t        ev_r, ev_nxt;

  function automatic logic nonpos(input logic [31:0] v);
    return (v == 32'd0) || v[31];
  endfunction

  always_comb begin
    logic [2:0]       c_phase;
    logic [31:0]      c_pos;
    logic [15:0]      c_magic;
    logic [15:0]      c_bitcnt;
    logic [31:0]      c_offset;
    logic [31:0]      c_width;
    logic [31:0]      c_height;
    logic [DIM_W-1:0] c_col;
    logic [DIM_W-1:0] c_row;
    logic [1:0]       c_bip;
    logic [15:0]      c_hold;
    logic [1:0]       c_pad;
    logic [5:0]       p;
    logic [5:0]       rel;
    logic [31:0]      pos_inc;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [DIM_W-1:0] h_dim;
    logic [DIM_W-1:0] w_dim;
    logic             wbig;
    logic             hbig;
    // file_start restarts the parse before this byte is looked at
    c_phase  = file_start ? PH_HEADER : phase_r;
    c_pos    = file_start ? '0 : pos_r;
    c_magic  = file_start ? '0 : magic_r;
    c_bitcnt = file_start ? '0 : bitcnt_r;
    c_offset = file_start ? '0 : offset_r;
    c_width  = file_start ? '0 : width_r;
    c_height = file_start ? '0 : height_r;
    c_col    = file_start ? '0 : col_r;
    c_row    = file_start ? '0 : row_r;
    c_bip    = file_start ? '0 : bip_r;
    c_hold   = file_start ? '0 : hold_r;
    c_pad    = file_start ? '0 : pad_r;

    phase_nxt  = c_phase;
    pos_nxt    = c_pos;
    magic_nxt  = c_magic;
    bitcnt_nxt = c_bitcnt;
    offset_nxt = c_offset;
    width_nxt  = c_width;
    height_nxt = c_height;
    col_nxt    = c_col;
    row_nxt    = c_row;
    bip_nxt    = c_bip;
    hold_nxt   = c_hold;
    pad_nxt    = c_pad;

    // header position stays below 54
    p       = c_pos[5:0];
    rel     = '0;
    pos_inc = c_pos + 32'd1;
    col_inc = c_col + DIM_W'(1);
    row_inc = c_row + DIM_W'(1);
    h_dim   = c_height[DIM_W-1:0];
    w_dim   = c_width[DIM_W-1:0];
    wbig    = !c_width[31] && (c_width > 32'(MAX_IMAGE_DIM));
    hbig    = !c_height[31] && (c_height > 32'(MAX_IMAGE_DIM));

    ev_nxt      = '0;
    ev_nxt.vld  = acc;
    ev_nxt.fx   = DIM_W'(origin_x) + c_col;
    ev_nxt.fy   = DIM_W'(origin_y) + (h_dim - DIM_W'(1) - c_row);
    ev_nxt.word = {file_byte, c_hold};

    unique case (c_phase)
      PH_HEADER: begin
        pos_nxt = pos_inc;
        if (p < 6'd2) begin
          magic_nxt[{p[0], 3'b000} +: 8] = c_magic[{p[0], 3'b000} +: 8] | file_byte;
        end else if (p >= 6'd10 && p < 6'd14) begin
          rel = p - 6'd10;
          offset_nxt[{rel[1:0], 3'b000} +: 8] = c_offset[{rel[1:0], 3'b000} +: 8] | file_byte;
        end else if (p >= 6'd18 && p < 6'd22) begin
          rel = p - 6'd18;
          width_nxt[{rel[1:0], 3'b000} +: 8] = c_width[{rel[1:0], 3'b000} +: 8] | file_byte;
        end else if (p >= 6'd22 && p < 6'd26) begin
          rel = p - 6'd22;
          height_nxt[{rel[1:0], 3'b000} +: 8] = c_height[{rel[1:0], 3'b000} +: 8] | file_byte;
        end else if (p >= 6'd28 && p < 6'd30) begin
          bitcnt_nxt[{p[0], 3'b000} +: 8] = c_bitcnt[{p[0], 3'b000} +: 8] | file_byte;
        end
        if (c_pos == 32'(HEADER_BYTES - 1)) begin
          if (c_magic != BMP_MAGIC || c_bitcnt != BMP_BPP24 || wbig || hbig) begin
            ev_nxt.stat = 1'b1;
            ev_nxt.kind = KIND_BADFMT;
            phase_nxt   = PH_IDLE;
          end else if (nonpos(c_width) || nonpos(c_height)) begin
            ev_nxt.stat = 1'b1;
            ev_nxt.kind = KIND_DONE;
            phase_nxt   = PH_IDLE;
          end else if (c_offset > 32'(HEADER_BYTES)) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_PIXEL;
          end
        end
      end
      PH_SKIP: begin
        pos_nxt = pos_inc;
        if (pos_inc >= c_offset) begin
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (c_bip == 2'd0) begin
          hold_nxt = {8'h00, file_byte};
          bip_nxt  = 2'd1;
        end else if (c_bip == 2'd1) begin
          hold_nxt[15:8] = file_byte;
          bip_nxt        = 2'd2;
        end else begin
          bip_nxt    = 2'd0;
          ev_nxt.pix = 1'b1;
          if (col_inc >= w_dim) begin
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_inc >= h_dim) begin
              ev_nxt.stat = 1'b1;
              ev_nxt.kind = KIND_DONE;
              phase_nxt   = PH_IDLE;
            end else begin
              pad_nxt = c_width[1:0];
              if (c_width[1:0] != 2'd0) begin
                phase_nxt = PH_PAD;
              end
            end
          end else begin
            col_nxt = col_inc;
          end
        end
      end
      PH_PAD: begin
        pad_nxt = c_pad - 2'd1;
        if (c_pad == 2'd1) begin
          phase_nxt = PH_PIXEL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      magic_r  <= '0;
      bitcnt_r <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      bip_r    <= '0;
      hold_r   <= '0;
      pad_r    <= '0;
      ev_r     <= '0;
    end else begin
      ev_r <= ev_nxt;
      if (acc) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        magic_r  <= magic_nxt;
        bitcnt_r <= bitcnt_nxt;
        offset_r <= offset_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        bip_r    <= bip_nxt;
        hold_r   <= hold_nxt;
        pad_r    <= pad_nxt;
      end
    end
  end

  assign ev = ev_r;

endmodule

// ===== sv/bmp24_outq.sv =====
// Result queue: each entry sends an optional pixel write then an optional status.
module bmp24_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bmp24_pkg::bmp24_res_t      push_ent,
  output logic [bmp24_pkg::Q_CW-1:0] level,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [55:0]                out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);
  import bmp24_pkg::*;

  bmp24_res_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic            sent_pix_r;
  bmp24_res_t      head;
  logic            send_pix;
  logic            hs;
  logic            pop;

  assign head     = mem_r[rd_ptr_r];
  assign send_pix = head.pix && !sent_pix_r;

  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = !(send_pix && head.stat);
  assign out_tuser  = send_pix ? KIND_PIX : head.kind;
  assign out_tdata  = send_pix ? {4'b0000, head.word, head.addr} : 56'd0;

  assign hs  = out_tvalid && out_tready;
  assign pop = hs && out_tlast;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      sent_pix_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r   <= rd_ptr_r + Q_AW'(1);
        sent_pix_r <= 1'b0;
      end else if (hs) begin
        sent_pix_r <= 1'b1;
      end
      cnt_r <= cnt_r + Q_CW'(push) - Q_CW'(pop);
    end
  end

  assign level = cnt_r;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the 24-bit BMP stream to framebuffer write decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp24_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES  = 300;
  localparam int N_ROWS        = 20;

  localparam logic [2:0] LAY_MAX     = 3'd0;
  localparam logic [2:0] LAY_CORNER  = 3'd1;
  localparam logic [2:0] LAY_ZERO    = 3'd2;
  localparam logic [2:0] LAY_PARTIAL = 3'd3;
  localparam logic [2:0] LAY_RESET   = 3'd4;
  localparam logic [2:0] LAY_KEEP    = 3'd7;

  typedef enum logic [2:0] {ST_HDR, ST_SKIP, ST_PIX, ST_PAD, ST_DONE} parse_state_t;

  typedef struct packed {
    logic [11:0] ox;
    logic [11:0] oy;
    logic [12:0] sw;
    logic [12:0] sh;
    logic [3:0]  bpp;
    logic [15:0] stride;
  } fb_settings_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [27:0] addr;
    logic [23:0] word;
    logic        last;
  } fb_result_t;

  // one file: settings to load first, header fields, truncation, typed status
  typedef struct packed {
    logic [2:0]  layout;
    logic        start;
    logic        squeeze;
    logic [15:0] magic;
    logic [15:0] depth;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] cut;
    logic        typed;
    logic [1:0]  typed_kind;
  } bmp_file_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = REG_ORIGIN_X;
  logic [15:0] cfg_wdata  = '0;

  bmp24_stream_to_framebuffer_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // decoder mirror
  fb_settings_t cur = '{ox: 12'd0, oy: 12'd0, sw: 13'd1024, sh: 13'd768,
                        bpp: 4'd4, stride: 16'd4096};
  parse_state_t pstate     = ST_HDR;
  logic [31:0]  fpos       = '0;
  logic [31:0]  doff       = '0;
  logic [31:0]  img_w      = '0;
  logic [31:0]  img_h      = '0;
  logic [15:0]  magic_acc  = '0;
  logic [15:0]  depth_acc  = '0;
  logic [12:0]  col        = '0;
  logic [12:0]  row        = '0;
  logic [1:0]   pix_byte   = '0;
  logic [1:0]   pad_left   = '0;
  logic [15:0]  bg_hold    = '0;

  fb_result_t byte_results[2];
  int         byte_result_cnt;
  fb_result_t due_fb_results[$];
  logic [7:0] file_bytes[$];

  int errors    = 0;
  int fed_bytes = 0;
  bit hold_req  = 1'b0;
  bit tx_burst  = 1'b0;
  bit rx_burst  = 1'b0;

  bmp_file_t directed_rows[N_ROWS] = '{
    // no file_start after reset
    '{LAY_KEEP,    1'b0, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd2, 32'd2, 16'd0, 1'b0, KIND_PIX},
    // widest row, receiver held off
    '{LAY_MAX,     1'b1, 1'b1, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd4096, 32'd1, 16'd80, 1'b0,
      KIND_PIX},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd0, 32'd1, 32'd4096, 16'd80, 1'b0,
      KIND_PIX},
    '{LAY_KEEP,    1'b1, 1'b0, 16'h4D43, BMP_BPP24, 32'd54, 32'd2, 32'd2, 16'd0, 1'b1,
      KIND_BADFMT},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, 16'd32, 32'd54, 32'd2, 32'd2, 16'd0, 1'b1,
      KIND_BADFMT},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd4097, 32'd1, 16'd0, 1'b1,
      KIND_BADFMT},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd1, 32'd4097, 16'd0, 1'b1,
      KIND_BADFMT},
    '{LAY_KEEP,    1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 16'd0, 1'b1, KIND_BADFMT},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd0, 32'd3, 16'd0, 1'b1,
      KIND_DONE},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd2, 32'hFFFF_FFFF, 16'd0,
      1'b1, KIND_DONE},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'h8000_0000, 32'd1, 16'd0,
      1'b1, KIND_DONE},
    // bad magic wins over empty size
    '{LAY_KEEP,    1'b1, 1'b0, 16'h0000, 16'h0000, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1,
      KIND_BADFMT},
    '{LAY_PARTIAL, 1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd0, 32'd1, 32'd1, 16'd0, 1'b0,
      KIND_PIX},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd58, 32'd3, 32'd2, 16'd0, 1'b0,
      KIND_PIX},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd55, 32'd5, 32'd3, 16'd0, 1'b0,
      KIND_PIX},
    '{LAY_CORNER,  1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd2, 32'd2, 16'd0, 1'b0,
      KIND_PIX},
    '{LAY_ZERO,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd3, 32'd1, 16'd0, 1'b0,
      KIND_PIX},
    // cut short, next file restarts mid-stream
    '{LAY_RESET,   1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd4, 32'd4, 16'd70, 1'b0,
      KIND_PIX},
    // offset never reached
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'h8000_0000, 32'd2, 32'd2, 16'd100,
      1'b0, KIND_PIX},
    '{LAY_KEEP,    1'b1, 1'b0, BMP_MAGIC, BMP_BPP24, 32'd54, 32'd6, 32'd3, 16'd0, 1'b0,
      KIND_PIX}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic fb_settings_t layout_settings(input logic [2:0] sel);
    fb_settings_t s;
    case (sel)
      LAY_MAX:     s = '{12'd0, 12'd0, 13'd4096, 13'd4096, 4'd8, 16'd65535};
      LAY_CORNER:  s = '{12'd4095, 12'd4095, 13'd4096, 13'd4096, 4'd1, 16'd1};
      LAY_ZERO:    s = '{12'd0, 12'd0, 13'd0, 13'd0, 4'd0, 16'd0};
      LAY_PARTIAL: s = '{12'd3, 12'd2, 13'd6, 13'd4, 4'd4, 16'd4096};
      default:     s = '{12'd0, 12'd0, 13'd1024, 13'd768, 4'd4, 16'd4096};
    endcase
    return s;
  endfunction

  function automatic fb_settings_t random_settings();
    fb_settings_t s;
    int v;
    s.ox = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4088, 4095))
                                       : 12'($urandom_range(0, 8));
    s.oy = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4088, 4095))
                                       : 12'($urandom_range(0, 8));
    case ($urandom_range(0, 3))
      0: v = 4096;
      1: v = 0;
      2: v = int'(s.ox) + $urandom_range(0, 6);
      default: v = $urandom_range(0, 4096);
    endcase
    s.sw = 13'((v > 4096) ? 4096 : v);
    case ($urandom_range(0, 3))
      0: v = 4096;
      1: v = 0;
      2: v = int'(s.oy) + $urandom_range(0, 6);
      default: v = $urandom_range(0, 4096);
    endcase
    s.sh = 13'((v > 4096) ? 4096 : v);
    s.bpp = 4'($urandom_range(0, 8));
    case ($urandom_range(0, 3))
      0: s.stride = 16'd0;
      1: s.stride = 16'hFFFF;
      default: s.stride = 16'($urandom_range(0, 65535));
    endcase
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("%0t ns: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic add_result(input logic [1:0] kind, input logic [27:0] addr,
                            input logic [23:0] word);
    byte_results[byte_result_cnt] = '{kind, addr, word, 1'b0};
    byte_result_cnt++;
  endtask

  // advance the mirror by one accepted byte; results land in byte_results
  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [31:0] p, fx, fy, addr;
    logic wide, tall;
    byte_result_cnt = 0;
    if (st) begin
      pstate = ST_HDR; fpos = '0; doff = '0; img_w = '0; img_h = '0;
      magic_acc = '0; depth_acc = '0; col = '0; row = '0;
      pix_byte = '0; pad_left = '0; bg_hold = '0;
    end
    case (pstate)
      ST_HDR: begin
        p = fpos;
        if (p < 2)
          magic_acc = magic_acc | (16'(b) << (8 * p));
        else if (p >= 10 && p < 14)
          doff = doff | (32'(b) << (8 * (p - 10)));
        else if (p >= 18 && p < 22)
          img_w = img_w | (32'(b) << (8 * (p - 18)));
        else if (p >= 22 && p < 26)
          img_h = img_h | (32'(b) << (8 * (p - 22)));
        else if (p >= 28 && p < 30)
          depth_acc = depth_acc | (16'(b) << (8 * (p - 28)));
        fpos = p + 1;
        if (p == HEADER_BYTES - 1) begin
          wide = !(img_w == 0 || img_w[31]) && img_w > 32'(MAX_IMAGE_DIM);
          tall = !(img_h == 0 || img_h[31]) && img_h > 32'(MAX_IMAGE_DIM);
          if (magic_acc != BMP_MAGIC || depth_acc != BMP_BPP24 || wide || tall) begin
            add_result(KIND_BADFMT, '0, '0);
            pstate = ST_DONE;
          end else if (img_w == 0 || img_w[31] || img_h == 0 || img_h[31]) begin
            add_result(KIND_DONE, '0, '0);
            pstate = ST_DONE;
          end else if (doff > 32'(HEADER_BYTES)) begin
            pstate = ST_SKIP;
          end else begin
            pstate = ST_PIX;
          end
        end
      end
      ST_SKIP: begin
        fpos = fpos + 1;
        if (fpos >= doff) pstate = ST_PIX;
      end
      ST_PIX: begin
        if (pix_byte == 2'd0) begin
          bg_hold = {8'h00, b};
          pix_byte = 2'd1;
        end else if (pix_byte == 2'd1) begin
          bg_hold = {b, bg_hold[7:0]};
          pix_byte = 2'd2;
        end else begin
          fx = 32'(cur.ox) + 32'(col);
          fy = 32'(cur.oy) + (img_h - 32'd1 - 32'(row));
          pix_byte = 2'd0;
          if (fx < 32'(cur.sw) && fy < 32'(cur.sh)) begin
            addr = fy * 32'(cur.stride) + fx * 32'(cur.bpp);
            add_result(KIND_PIX, addr[27:0], {b, bg_hold});
          end
          col = col + 1'b1;
          if (32'(col) >= img_w) begin
            col = '0;
            row = row + 1'b1;
            if (32'(row) >= img_h) begin
              add_result(KIND_DONE, '0, '0);
              pstate = ST_DONE;
            end else begin
              pad_left = img_w[1:0];
              if (pad_left != 2'd0) pstate = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) pstate = ST_PIX;
      end
      default: ;
    endcase
    if (byte_result_cnt > 0) byte_results[byte_result_cnt - 1].last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st, input logic typed);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, st);
    if (!typed)
      for (int k = 0; k < byte_result_cnt; k++) due_fb_results.push_back(byte_results[k]);
  endtask

  // stop sending, let every awaited result drain, then let the pipe go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_fb_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input fb_settings_t s);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_wdata <= 16'(s.ox);
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_wdata <= 16'(s.oy);
    @(posedge clk);
    cfg_index <= REG_SCREEN_W;
    cfg_wdata <= 16'(s.sw);
    @(posedge clk);
    cfg_index <= REG_SCREEN_H;
    cfg_wdata <= 16'(s.sh);
    @(posedge clk);
    cfg_index <= REG_BPP;
    cfg_wdata <= 16'(s.bpp);
    @(posedge clk);
    cfg_index <= REG_STRIDE;
    cfg_wdata <= s.stride;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur = s;
  endtask

  task automatic play_file(input bmp_file_t f);
    int i, body_len;
    file_bytes.delete();
    for (i = 0; i < HEADER_BYTES; i++) file_bytes.push_back(8'($urandom));
    file_bytes[0]  = f.magic[7:0];
    file_bytes[1]  = f.magic[15:8];
    file_bytes[28] = f.depth[7:0];
    file_bytes[29] = f.depth[15:8];
    for (i = 0; i < 4; i++) begin
      file_bytes[10 + i] = f.offset[8*i +: 8];
      file_bytes[18 + i] = f.width[8*i +: 8];
      file_bytes[22 + i] = f.height[8*i +: 8];
    end
    if (f.magic == BMP_MAGIC && f.depth == BMP_BPP24 &&
        f.width >= 1 && f.width <= MAX_IMAGE_DIM &&
        f.height >= 1 && f.height <= MAX_IMAGE_DIM) begin
      for (i = HEADER_BYTES; i < f.offset && i < 100; i++) file_bytes.push_back(8'($urandom));
      repeat (f.height)
        repeat (f.width * 3 + f.width[1:0]) file_bytes.push_back(8'($urandom));
    end
    body_len = file_bytes.size();
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
    if (f.cut != 0)
      while (file_bytes.size() > f.cut) void'(file_bytes.pop_back());
    fed_bytes += (file_bytes.size() < body_len) ? file_bytes.size() : body_len;

    tx_burst = f.squeeze || ($urandom_range(0, 3) == 0);
    if (f.squeeze) hold_req = 1'b1;
    for (i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], f.start && i == 0, f.typed);
      if (f.typed && i == HEADER_BYTES - 1)
        due_fb_results.push_back({f.typed_kind, 28'd0, 24'd0, 1'b1});
    end
  endtask

  // result side
  initial begin
    fb_result_t exp;
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (due_fb_results.size() == 0) begin
        flag_mismatch("unexpected result kind", 32'(out_tuser), 32'(KIND_PIX));
      end else begin
        exp = due_fb_results.pop_front();
        if (out_tuser !== exp.kind)
          flag_mismatch("kind", 32'(out_tuser), 32'(exp.kind));
        if (out_tdata[27:0] !== exp.addr)
          flag_mismatch("write address", 32'(out_tdata[27:0]), 32'(exp.addr));
        if (out_tdata[51:28] !== exp.word)
          flag_mismatch("pixel word", 32'(out_tdata[51:28]), 32'(exp.word));
        if (out_tdata[55:52] !== 4'd0)
          flag_mismatch("tdata fill", 32'(out_tdata[55:52]), 32'd0);
        if (out_tlast !== exp.last)
          flag_mismatch("last", 32'(out_tlast), 32'(exp.last));
      end
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
    end
  end

  // watchdog: cycles with no request moving on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bmp_file_t f;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].layout != LAY_KEEP) begin
        settle();
        load_settings(layout_settings(directed_rows[r].layout));
      end
      play_file(directed_rows[r]);
    end

    fed_bytes = 0;
    while (fed_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        load_settings(random_settings());
      end
      f = '0;
      f.layout = LAY_KEEP;
      f.start  = ($urandom_range(0, 15) != 0);
      f.magic  = BMP_MAGIC;
      f.depth  = BMP_BPP24;
      f.width  = $urandom_range(1, 6);
      f.height = $urandom_range(1, 4);
      case ($urandom_range(0, 3))
        0: f.offset = $urandom_range(0, 53);
        1: f.offset = $urandom_range(55, 70);
        default: f.offset = HEADER_BYTES;
      endcase
      case ($urandom_range(0, 9))
        7: begin
          f.offset = $urandom;
          case ($urandom_range(0, 4))
            0: f.magic = 16'($urandom) ^ ((16'($urandom) == BMP_MAGIC) ? 16'h1 : 16'h0);
            1: f.depth = (16'($urandom) | 16'h0100);
            2: f.width = $urandom | 32'h0000_2000;
            3: f.height = $urandom | 32'h0000_2000;
            default: f.height = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
          endcase
          play_file(f);
        end
        8: begin
          f.cut = $urandom_range(1, 120);
          play_file(f);
        end
        9: begin
          // stray bytes with no file start
          n = $urandom_range(1, 6);
          tx_burst = 1'b0;
          repeat (n) send_byte(8'($urandom), 1'b0, 1'b0);
        end
        default: play_file(f);
      endcase
    end

    in_tvalid <= 1'b0;
    while (due_fb_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bmp24_pkg.sv
sv/bmp24_parse.sv
sv/bmp24_outq.sv
sv/bmp24_stream_to_framebuffer_top.sv
bench/tb.sv
